### hw/rtl/rau_pkg.sv
package rau_pkg;

  localparam int DEF_OPERAND_WIDTH = 16;
  localparam int FIELD_W           = 16;
  localparam int CMD_W             = 3;
  localparam int RES_NUM_W         = 33;
  localparam int RES_DEN_W         = 31;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;

  // multiplier operand selection
  localparam logic [1:0] MUL_X = 2'd0;  // a_num * b_den
  localparam logic [1:0] MUL_Y = 2'd1;  // b_num * a_den
  localparam logic [1:0] MUL_D = 2'd2;  // a_den * b_den
  localparam logic [1:0] MUL_N = 2'd3;  // a_num * b_num

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        is_less;
    logic                        is_equal;
    logic                        is_greater;
    logic                        div_by_zero;
    logic                        zero_den_fixed;
  } rau_out_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       form;
    logic       gcd_start;
    logic       div_start;
    logic       div_den;
    logic       cap_num;
    logic       cap_den;
    logic       out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } rau_sts_t;

endpackage

### hw/rtl/rau_gcd.sv
module rau_gcd #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] u_in,
  input  logic [DW-1:0] v_in,
  output logic          done,
  output logic [DW-1:0] g
);

  localparam int KW = $clog2(DW + 1);

  logic [DW-1:0] u_r, u_nxt;
  logic [DW-1:0] v_r, v_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [DW-1:0] g_r, g_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    u_nxt    = u_r;
    v_nxt    = v_r;
    k_nxt    = k_r;
    g_nxt    = g_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      u_nxt    = u_in;
      v_nxt    = v_in;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (u_r == '0 || v_r == '0) begin
        g_nxt    = (u_r | v_r) << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!u_r[0] && !v_r[0]) begin
        u_nxt = u_r >> 1;
        v_nxt = v_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!u_r[0]) begin
        u_nxt = u_r >> 1;
      end else if (!v_r[0]) begin
        v_nxt = v_r >> 1;
      end else if (u_r >= v_r) begin
        u_nxt = u_r - v_r;
      end else begin
        v_nxt = v_r - u_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    v_r <= v_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
  end

  assign done = done_r;
  assign g    = g_r;

endmodule

### hw/rtl/rau_div.sv
module rau_div #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [DW-1:0] dv_r, dv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, q_r[DW-1]};
  assign diff  = trial - {1'b0, dv_r};
  assign ge    = trial >= {1'b0, dv_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      dv_nxt   = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_nxt   = {q_r[DW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### hw/rtl/rau_ctrl.sv
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output rau_pkg::rau_cmd_t cmd,
  input  rau_pkg::rau_sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PX    = 4'd1;
  localparam logic [3:0] S_PY    = 4'd2;
  localparam logic [3:0] S_PD    = 4'd3;
  localparam logic [3:0] S_PN    = 4'd4;
  localparam logic [3:0] S_FORM  = 4'd5;
  localparam logic [3:0] S_GST   = 4'd6;
  localparam logic [3:0] S_GWAIT = 4'd7;
  localparam logic [3:0] S_NST   = 4'd8;
  localparam logic [3:0] S_NWAIT = 4'd9;
  localparam logic [3:0] S_DST   = 4'd10;
  localparam logic [3:0] S_DWAIT = 4'd11;
  localparam logic [3:0] S_LOAD  = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PX;
        end
      end
      S_PX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_X;
        state_nxt   = S_PY;
      end
      S_PY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_Y;
        state_nxt   = S_PD;
      end
      S_PD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_D;
        state_nxt   = S_PN;
      end
      S_PN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_N;
        state_nxt   = S_FORM;
      end
      S_FORM: begin
        cmd.form  = 1'b1;
        state_nxt = S_GST;
      end
      S_GST: begin
        cmd.gcd_start = 1'b1;
        state_nxt     = S_GWAIT;
      end
      S_GWAIT: begin
        if (sts.gcd_done) begin
          state_nxt = S_NST;
        end
      end
      S_NST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_NWAIT;
      end
      S_NWAIT: begin
        if (sts.div_done) begin
          cmd.cap_num = 1'b1;
          state_nxt   = S_DST;
        end
      end
      S_DST: begin
        cmd.div_start = 1'b1;
        cmd.div_den   = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.cap_den = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/rau_datapath.sv
module rau_datapath #(
  parameter int OPERAND_WIDTH = rau_pkg::DEF_OPERAND_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::rau_in_t  in_data,
  output rau_pkg::rau_out_t out_data,
  input  rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_sts_t sts
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * W;
  localparam int EW = (W > rau_pkg::FIELD_W) ? W : rau_pkg::FIELD_W;
  localparam int NW = (DW > rau_pkg::RES_NUM_W) ? DW : rau_pkg::RES_NUM_W;
  localparam int QW = (DW > rau_pkg::RES_DEN_W) ? DW : rau_pkg::RES_DEN_W;

  // operand sign and magnitude
  logic [EW-1:0] an_z, ad_z, bn_z, bd_z;
  logic [W-1:0]  an_w, ad_w, bn_w, bd_w;
  logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
  logic          ad_zero, bd_zero;

  assign an_z = EW'($unsigned(in_data.a_num));
  assign ad_z = EW'($unsigned(in_data.a_den));
  assign bn_z = EW'($unsigned(in_data.b_num));
  assign bd_z = EW'($unsigned(in_data.b_den));
  assign an_w = an_z[W-1:0];
  assign ad_w = ad_z[W-1:0];
  assign bn_w = bn_z[W-1:0];
  assign bd_w = bd_z[W-1:0];

  assign ad_zero = (ad_w == '0);
  assign bd_zero = (bd_w == '0);
  assign an_mag  = an_w[W-1] ? (~an_w + 1'b1) : an_w;
  assign bn_mag  = bn_w[W-1] ? (~bn_w + 1'b1) : bn_w;
  assign ad_mag  = ad_zero ? W'(1) : (ad_w[W-1] ? (~ad_w + 1'b1) : ad_w);
  assign bd_mag  = bd_zero ? W'(1) : (bd_w[W-1] ? (~bd_w + 1'b1) : bd_w);

  logic [rau_pkg::CMD_W-1:0] cmd_r;
  logic                      a_neg_r, b_neg_r, fixed_r;
  logic [W-1:0]              an_r, ad_r, bn_r, bd_r;
  logic [DW-1:0]             x_r, y_r, pd_r, pn_r;
  logic [DW-1:0]             n_r, n_nxt, d_r, d_nxt;
  logic                      neg_r, neg_nxt;
  logic                      lt_r, lt_nxt, eq_r, eq_nxt, gt_r, gt_nxt, dz_r, dz_nxt;
  logic [DW-1:0]             qn_r, qd_r;
  rau_pkg::rau_out_t         out_r, out_nxt;

  // shared multiplier
  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      rau_pkg::MUL_X: begin
        mul_a = an_r;
        mul_b = bd_r;
      end
      rau_pkg::MUL_Y: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      rau_pkg::MUL_D: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
      default: begin
        mul_a = an_r;
        mul_b = bn_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // signed sum of the cross products
  logic          y_neg;
  logic          s_neg;
  logic [DW-1:0] s_mag;

  assign y_neg = b_neg_r ^ ((cmd_r == rau_pkg::CMD_SUB) || (cmd_r == rau_pkg::CMD_CMP));

  always_comb begin
    if (a_neg_r == y_neg) begin
      s_neg = a_neg_r;
      s_mag = x_r + y_r;
    end else if (x_r >= y_r) begin
      s_neg = a_neg_r;
      s_mag = x_r - y_r;
    end else begin
      s_neg = y_neg;
      s_mag = y_r - x_r;
    end
    if (s_mag == '0) begin
      s_neg = 1'b0;
    end
  end

  always_comb begin
    n_nxt   = '0;
    d_nxt   = DW'(1);
    neg_nxt = 1'b0;
    lt_nxt  = 1'b0;
    eq_nxt  = 1'b0;
    gt_nxt  = 1'b0;
    dz_nxt  = 1'b0;
    case (cmd_r)
      rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
        n_nxt   = s_mag;
        d_nxt   = pd_r;
        neg_nxt = s_neg;
      end
      rau_pkg::CMD_MUL: begin
        n_nxt   = pn_r;
        d_nxt   = pd_r;
        neg_nxt = a_neg_r ^ b_neg_r;
      end
      rau_pkg::CMD_DIV: begin
        if (bn_r == '0) begin
          dz_nxt = 1'b1;
        end else begin
          n_nxt   = x_r;
          d_nxt   = y_r;
          neg_nxt = a_neg_r ^ b_neg_r;
        end
      end
      rau_pkg::CMD_CMP: begin
        lt_nxt = s_neg;
        eq_nxt = (s_mag == '0);
        gt_nxt = !s_neg && (s_mag != '0);
      end
      default: begin
        n_nxt = '0;
      end
    endcase
  end

  // reduction by gcd and exact division
  logic          gcd_done, div_done;
  logic [DW-1:0] g, quot;

  rau_gcd #(.DW(DW)) u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.gcd_start),
    .u_in  (n_r),
    .v_in  (d_r),
    .done  (gcd_done),
    .g     (g)
  );

  rau_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_den ? d_r : n_r),
    .divisor  (g),
    .done     (div_done),
    .quot     (quot)
  );

  assign sts.gcd_done = gcd_done;
  assign sts.div_done = div_done;

  // result formatting
  logic [NW-1:0] qn_x, qn_s;
  logic [QW-1:0] qd_x;

  assign qn_x = NW'(qn_r);
  assign qn_s = neg_r ? (~qn_x + 1'b1) : qn_x;
  assign qd_x = QW'(qd_r);

  always_comb begin
    out_nxt                = out_r;
    out_nxt.res_num        = qn_s[rau_pkg::RES_NUM_W-1:0];
    out_nxt.res_den        = qd_x[rau_pkg::RES_DEN_W-1:0];
    out_nxt.is_less        = lt_r;
    out_nxt.is_equal       = eq_r;
    out_nxt.is_greater     = gt_r;
    out_nxt.div_by_zero    = dz_r;
    out_nxt.zero_den_fixed = fixed_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r   <= in_data.command;
      a_neg_r <= an_w[W-1] ^ ad_w[W-1];
      b_neg_r <= bn_w[W-1] ^ bd_w[W-1];
      fixed_r <= ad_zero || bd_zero;
      an_r    <= an_mag;
      ad_r    <= ad_mag;
      bn_r    <= bn_mag;
      bd_r    <= bd_mag;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rau_pkg::MUL_X: x_r  <= prod;
        rau_pkg::MUL_Y: y_r  <= prod;
        rau_pkg::MUL_D: pd_r <= prod;
        default:        pn_r <= prod;
      endcase
    end
    if (cmd.form) begin
      n_r   <= n_nxt;
      d_r   <= d_nxt;
      neg_r <= neg_nxt;
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
      gt_r  <= gt_nxt;
      dz_r  <= dz_nxt;
    end
    if (cmd.cap_num) begin
      qn_r <= quot;
    end
    if (cmd.cap_den) begin
      qd_r <= quot;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

### hw/rtl/rational_arithmetic_unit_top.sv
// the result is formed from the input transfer through the four products, the signed sum,
// a binary gcd loop over 2*OPERAND_WIDTH-bit values and two exact divisions by the gcd;
// one item in flight at a time
// next input transfer is taken once the result sits in the output register
// reset (synchronous, active low) returns the controller to idle and empties the output
module rational_arithmetic_unit_top #(
  parameter int OPERAND_WIDTH = rau_pkg::DEF_OPERAND_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rau_pkg::rau_out_t out_data
);

  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
